// ----- src/ctd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctd_pkg: shared types and constants for the CLUT texel decoder
// Memory geometry, field positions of the page and palette words, command,
// depth and register codes, and the 5-bit to 8-bit channel expansion table.
// ----------------------------------------------------------------------------
package ctd_pkg;

	// Memory geometry; all three are powers of two so that every wrap is a
	// plain truncation and every halfword fetch is word aligned
	localparam int unsigned ROW_BYTES = 2048;
	localparam int unsigned ROW_COUNT = 512;
	localparam int unsigned PAGE_SIZE = 256;

	localparam int unsigned MEM_BYTES = ROW_BYTES * ROW_COUNT;
	localparam int unsigned MEM_WORDS = MEM_BYTES / 2;
	localparam int unsigned BYTE_AW   = $clog2(MEM_BYTES);
	localparam int unsigned WORD_AW   = BYTE_AW - 1;
	localparam int unsigned ROW_SHIFT = $clog2(ROW_BYTES);
	localparam int unsigned PAGE_W    = $clog2(PAGE_SIZE);
	localparam int unsigned ROW_W     = PAGE_W + 1;

	localparam int unsigned WORD_W    = 16;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Page word fields
	localparam int unsigned TP_XBASE_LSB = 0;
	localparam int unsigned TP_XBASE_W   = 4;
	localparam int unsigned TP_YBASE_BIT = 4;
	localparam int unsigned TP_DEPTH_LSB = 7;
	localparam int unsigned TX_SHIFT     = 7;   // x base counts 128-byte units

	// Palette word fields
	localparam int unsigned PAL_X_W     = 6;
	localparam int unsigned PAL_X_SHIFT = 5;    // 16 colours of 2 bytes
	localparam int unsigned PAL_Y_W     = CFG_W - PAL_X_W;

	localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
	localparam logic [7:0] ALPHA_HALF   = 8'd128;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	typedef logic [BYTE_AW-1:0] byte_addr_t;
	typedef logic [WORD_AW-1:0] word_addr_t;
	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [ROW_W-1:0]   row_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_FETCH = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		DEPTH_4BIT     = 2'd0,
		DEPTH_8BIT     = 2'd1,
		DEPTH_DIRECT   = 2'd2,
		DEPTH_RESERVED = 2'd3
	} depth_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEXTURE_PAGE   = 2'd0,
		REG_PALETTE_SELECT = 2'd1,
		REG_SEMI_ENABLE    = 2'd2
	} reg_idx_t;

	// (v * 255 + 15) / 31 for every 5-bit channel value
	localparam logic [7:0] EXPAND5_LUT [32] = '{
		8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
		8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
		8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
		8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
	};

endpackage
`default_nettype wire

// ----- src/ctd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctd_ram: single-port synchronous RAM
// One access per cycle, write or read; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module ctd_ram #(
	parameter int unsigned WIDTH = ctd_pkg::WORD_W,
	parameter int unsigned DEPTH = ctd_pkg::MEM_WORDS
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write, or read into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- src/clut_texel_decode_rgba.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clut_texel_decode_rgba: video memory with CLUT texel lookup to RGBA8
// Holds the video memory, takes word writes and texel fetches, and returns
// one RGBA8 texel per fetch through 4-bit or 8-bit palettes or direct colour.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                         Moves
//  -------  ----------------------------------------------  -----------------
//  cfg      cfg_we, cfg_index, cfg_data                     register write
//  in       in_valid/in_ready, command, word_address,       write or fetch
//           word_data, texel_x, texel_y                     request
//  out      out_valid/out_ready, red, green, blue, alpha    texel result
//
//  A write or a direct-colour fetch uses the RAM port for one access; a
//  paletted fetch uses it for two (index word, then colour word), and
//  in_ready is low while it holds stage 1. A fetch result passes stage 1
//  and stage 2 into the output register. Reset clears the config registers
//  and pipeline valid flags; memory contents are undefined until written.
//  With out_ready low the pipeline fills and then holds, and in_ready drops.
//
module clut_texel_decode_rgba (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	input  wire logic                            cfg_we,
	input  wire logic [ctd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ctd_pkg::CFG_W-1:0]       cfg_data,

	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            command,
	input  wire logic [18:0]                     word_address,
	input  wire logic [15:0]                     word_data,
	input  wire logic [7:0]                      texel_x,
	input  wire logic [7:0]                      texel_y,

	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [7:0]                           red,
	output logic [7:0]                           green,
	output logic [7:0]                           blue,
	output logic [7:0]                           alpha
);

	// Configuration registers
	logic [ctd_pkg::CFG_W-1:0] texture_page_q;
	logic [ctd_pkg::CFG_W-1:0] palette_select_q;
	logic                      semi_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texture_page_q   <= '0;
			palette_select_q <= '0;
			semi_enable_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (ctd_pkg::reg_idx_t'(cfg_index))
				ctd_pkg::REG_TEXTURE_PAGE:   texture_page_q   <= cfg_data;
				ctd_pkg::REG_PALETTE_SELECT: palette_select_q <= cfg_data;
				ctd_pkg::REG_SEMI_ENABLE:    semi_enable_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Page word decode
	ctd_pkg::depth_t     page_depth;
	ctd_pkg::byte_addr_t page_x_base;
	ctd_pkg::row_t       tex_row;
	ctd_pkg::byte_addr_t tex_x_off;
	ctd_pkg::byte_addr_t tex_byte;

	assign page_depth  = ctd_pkg::depth_t'(texture_page_q[ctd_pkg::TP_DEPTH_LSB +: 2]);
	assign page_x_base = ctd_pkg::byte_addr_t'(
		texture_page_q[ctd_pkg::TP_XBASE_LSB +: ctd_pkg::TP_XBASE_W]) << ctd_pkg::TX_SHIFT;
	assign tex_row     = {texture_page_q[ctd_pkg::TP_YBASE_BIT],
		texel_y[ctd_pkg::PAGE_W-1:0]};

	// Byte offset of the texel inside its row, by depth
	always_comb begin
		unique case (page_depth)
			ctd_pkg::DEPTH_4BIT:
				tex_x_off = ctd_pkg::byte_addr_t'(texel_x[ctd_pkg::PAGE_W-1:1]);
			ctd_pkg::DEPTH_8BIT:
				tex_x_off = ctd_pkg::byte_addr_t'(texel_x[ctd_pkg::PAGE_W-1:0]);
			ctd_pkg::DEPTH_DIRECT:
				tex_x_off = ctd_pkg::byte_addr_t'(texel_x[ctd_pkg::PAGE_W-1:0]) << 1;
			default:
				tex_x_off = '0;
		endcase
	end

	assign tex_byte = (ctd_pkg::byte_addr_t'(tex_row) << ctd_pkg::ROW_SHIFT)
		+ page_x_base + tex_x_off;

	// Pipeline and output registers
	logic                v_s1;
	ctd_pkg::depth_t     depth_s1;
	logic                bsel_s1;
	logic                nsel_s1;
	logic                pal_s1;
	logic                v_s2;
	logic                pal_s2;
	ctd_pkg::word_t      col_s2;
	logic                out_valid_q;
	logic [7:0]          red_q;
	logic [7:0]          green_q;
	logic [7:0]          blue_q;
	logic [7:0]          alpha_q;

	// Flow control
	logic                out_free;
	logic                stall_s2;
	logic                pal_rd;
	logic                in_fire;
	logic                in_write;

	assign out_free = !out_valid_q || out_ready;
	assign stall_s2 = v_s2 && !out_free;
	assign pal_s1   = (depth_s1 == ctd_pkg::DEPTH_4BIT) || (depth_s1 == ctd_pkg::DEPTH_8BIT);
	assign pal_rd   = v_s1 && pal_s1 && !stall_s2;
	assign in_ready = !stall_s2 && !(v_s1 && pal_s1);
	assign in_fire  = in_valid && in_ready;
	assign in_write = (ctd_pkg::cmd_t'(command) == ctd_pkg::CMD_WRITE);

	// Palette index from the texel word, and the colour-table address
	ctd_pkg::word_t      ram_rdata;
	logic [7:0]          idx_byte;
	logic [7:0]          pal_idx;
	ctd_pkg::byte_addr_t pal_byte;

	assign idx_byte = bsel_s1 ? ram_rdata[15:8] : ram_rdata[7:0];
	assign pal_idx  = (depth_s1 == ctd_pkg::DEPTH_4BIT)
		? {4'd0, (nsel_s1 ? idx_byte[7:4] : idx_byte[3:0])} : idx_byte;
	assign pal_byte =
		(ctd_pkg::byte_addr_t'(palette_select_q[ctd_pkg::CFG_W-1:ctd_pkg::PAL_X_W])
			<< ctd_pkg::ROW_SHIFT)
		+ (ctd_pkg::byte_addr_t'(palette_select_q[ctd_pkg::PAL_X_W-1:0])
			<< ctd_pkg::PAL_X_SHIFT)
		+ (ctd_pkg::byte_addr_t'(pal_idx) << 1);

	// RAM port: palette read first, else the accepted request
	logic                ram_en;
	logic                ram_we;
	ctd_pkg::word_addr_t ram_addr;

	always_comb begin
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = tex_byte[ctd_pkg::BYTE_AW-1:1];
		priority if (pal_rd) begin
			ram_en   = 1'b1;
			ram_addr = pal_byte[ctd_pkg::BYTE_AW-1:1];
		end else if (in_fire && in_write) begin
			ram_en   = 1'b1;
			ram_we   = 1'b1;
			ram_addr = ctd_pkg::word_addr_t'(word_address);
		end else if (in_fire && page_depth != ctd_pkg::DEPTH_RESERVED) begin
			ram_en   = 1'b1;
		end else begin
			ram_en   = 1'b0;
		end
	end

	ctd_ram #(
		.WIDTH (ctd_pkg::WORD_W),
		.DEPTH (ctd_pkg::MEM_WORDS)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (word_data),
		.rdata (ram_rdata)
	);

	// Stage 1: texel word read in flight; hold while stage 2 is stuck
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!stall_s2) begin
			v_s1 <= in_fire && !in_write;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			depth_s1 <= page_depth;
			bsel_s1  <= tex_byte[0];
			nsel_s1  <= texel_x[0];
		end
	end

	// Stage 2: colour word from the palette read, or captured direct colour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!stall_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s2) begin
			pal_s2 <= pal_s1;
			col_s2 <= (depth_s1 == ctd_pkg::DEPTH_DIRECT) ? ram_rdata : '0;
		end
	end

	// Colour expansion and alpha
	ctd_pkg::word_t col;
	logic [7:0]     alpha_d;

	assign col = pal_s2 ? ram_rdata : col_s2;

	always_comb begin
		priority if (col == '0) begin
			alpha_d = ctd_pkg::ALPHA_CLEAR;
		end else if (semi_enable_q && col[15] && (col[14:0] != '0)) begin
			alpha_d = ctd_pkg::ALPHA_HALF;
		end else begin
			alpha_d = ctd_pkg::ALPHA_OPAQUE;
		end
	end

	// Output register: load when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (v_s2 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && out_free) begin
			red_q   <= ctd_pkg::EXPAND5_LUT[col[4:0]];
			green_q <= ctd_pkg::EXPAND5_LUT[col[9:5]];
			blue_q  <= ctd_pkg::EXPAND5_LUT[col[14:10]];
			alpha_q <= alpha_d;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign alpha     = alpha_q;

endmodule
`default_nettype wire
